// File: src/dbpid_pkg.sv
// Shared widths, reset values and register indexes of the deadband PID regulator.
`default_nettype none

package dbpid_pkg;

   // Field widths.
   localparam int ErrW  = 16;
   localparam int GainW = 20;
   localparam int DzW   = 15;
   localparam int LimW  = 31;
   localparam int SumW  = 32;
   localparam int DiffW = ErrW + 1;
   localparam int OutW  = 16;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 31;

   // Product and accumulator widths (gains are treated as signed with a zero sign bit).
   localparam int PropW  = GainW + 1 + ErrW;
   localparam int IntW   = GainW + 1 + SumW;
   localparam int DerW   = GainW + 1 + DiffW;
   localparam int AccW   = IntW + 2;
   localparam int ProdShift = 20;
   localparam int QuotW  = AccW - ProdShift;

   // Register reset values.
   localparam logic [GainW-1:0] KpReset  = GainW'(819200);
   localparam logic [GainW-1:0] KiReset  = GainW'(205);
   localparam logic [GainW-1:0] KdReset  = GainW'(12288);
   localparam logic [DzW-1:0]   DzReset  = DzW'(128);
   localparam logic [LimW-1:0]  LimReset = LimW'(5632000);

   // Register indexes of the configuration port.
   typedef enum logic [CsrIdxW-1:0] {
      CSR_PROPORTIONAL_GAIN = 3'd0,
      CSR_INTEGRAL_GAIN     = 3'd1,
      CSR_DERIVATIVE_GAIN   = 3'd2,
      CSR_DEAD_ZONE         = 3'd3,
      CSR_INTEGRAL_LIMIT    = 3'd4
   } csr_index_type;

   typedef logic signed [ErrW-1:0] sample_type;
   typedef logic signed [OutW-1:0] drive_type;

endpackage

`default_nettype wire

// File: src/dbpid_if.sv
// Request and response channel interfaces of the deadband PID regulator.
`default_nettype none

interface dbpid_req_if;
   import dbpid_pkg::*;
   logic       valid;
   logic       ready;
   sample_type error_sample;

   modport source (output valid, output error_sample, input ready);
   modport sink   (input valid, input error_sample, output ready);
endinterface

interface dbpid_rsp_if;
   import dbpid_pkg::*;
   logic      valid;
   logic      ready;
   drive_type drive_value;
   logic      in_dead_zone;

   modport source (output valid, output drive_value, output in_dead_zone, input ready);
   modport sink   (input valid, input drive_value, input in_dead_zone, output ready);
endinterface

`default_nettype wire

// File: src/deadband_pid_regulator.sv
// Deadband PID regulator: four-stage pipeline from error request to drive command.
//
// Usage: each request on req_ch carries one signed Q7.8 error sample; each
// request produces exactly one response on rsp_ch with a saturated int16
// drive command and a flag that tells whether the sample fell inside the
// dead zone. Gains, dead zone and integral limit are written through the
// csr_ port (write enable, index, data) while no request is in flight.
// Path: a request passes the input register, state update, multipliers and
// output register in that order. Throughput: one request per cycle while
// rsp_ch.ready holds. The integral and last-error update is the only loop
// and closes within the state-update stage, so each sample sees the state
// left by the one before it.
// Stalls: every stage has its own valid bit and moves forward whenever the
// stage after it is empty or moving, so the block keeps accepting requests
// while a finished response waits, until all four stages are full.
// Reset: synchronous and active high; it empties the pipeline, clears the
// integral sum and the last error, and loads the register reset values.
`default_nettype none

module deadband_pid_regulator (
   input  wire                                 clock,
   input  wire                                 reset,
   dbpid_req_if.sink                           req_ch,
   dbpid_rsp_if.source                         rsp_ch,
   input  wire                                 csr_we,
   input  wire  [dbpid_pkg::CsrIdxW-1:0]       csr_index,
   input  wire  [dbpid_pkg::CsrDataW-1:0]      csr_wdata
);
   import dbpid_pkg::*;

   // Configuration registers.
   logic [GainW-1:0] kp_ff, ki_ff, kd_ff;
   logic [DzW-1:0]   dead_zone_ff;
   logic [LimW-1:0]  limit_ff;

   // Controller state.
   logic signed [SumW-1:0] integral_ff, integral_in;
   logic signed [ErrW-1:0] last_error_ff;

   // Stage valid bits and advance enables.
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic en1, en2, en3, en4;

   // Stage 1: input register.
   logic signed [ErrW-1:0] e1_ff;

   // Stage 2: dead-zone decision, integral and derivative.
   logic signed [ErrW-1:0]  e2_ff;
   logic signed [SumW-1:0]  sum2_ff;
   logic signed [DiffW-1:0] diff2_ff;
   logic                    dz2_ff;

   // Stage 3: registered products.
   logic signed [PropW-1:0] prop3_ff;
   logic signed [IntW-1:0]  int3_ff;
   logic signed [DerW-1:0]  der3_ff;
   logic                    dz3_ff;

   // Stage 4: response register.
   logic signed [OutW-1:0]  drive4_ff, drive4_in;
   logic                    dz4_ff;

   // Each stage moves when the next one is empty or moving too.
   assign en4 = !v4_ff || rsp_ch.ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_ch.ready = en1;

   // Configuration writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff        <= KpReset;
         ki_ff        <= KiReset;
         kd_ff        <= KdReset;
         dead_zone_ff <= DzReset;
         limit_ff     <= LimReset;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PROPORTIONAL_GAIN: kp_ff        <= csr_wdata[GainW-1:0];
            CSR_INTEGRAL_GAIN:     ki_ff        <= csr_wdata[GainW-1:0];
            CSR_DERIVATIVE_GAIN:   kd_ff        <= csr_wdata[GainW-1:0];
            CSR_DEAD_ZONE:         dead_zone_ff <= csr_wdata[DzW-1:0];
            CSR_INTEGRAL_LIMIT:    limit_ff     <= csr_wdata[LimW-1:0];
            default: ;
         endcase
      end
   end

   // Magnitude of the sample; the most negative code maps to 32768.
   logic signed [DiffW-1:0] e1_ext;
   logic        [DiffW-1:0] mag1;
   logic                    dz1;
   assign e1_ext = {e1_ff[ErrW-1], e1_ff};
   assign mag1   = e1_ff[ErrW-1] ? (DiffW'(0) - e1_ext) : e1_ext;
   assign dz1    = mag1 < {{(DiffW-DzW){1'b0}}, dead_zone_ff};

   // Integral update with a symmetric clamp after the addition.
   logic signed [SumW:0] sum_raw, lim_pos, lim_neg;
   assign sum_raw = {integral_ff[SumW-1], integral_ff} + {{(SumW+1-ErrW){e1_ff[ErrW-1]}}, e1_ff};
   assign lim_pos = {2'b00, limit_ff};
   assign lim_neg = -lim_pos;

   always_comb begin
      if (sum_raw > lim_pos) begin
         integral_in = lim_pos[SumW-1:0];
      end else if (sum_raw < lim_neg) begin
         integral_in = lim_neg[SumW-1:0];
      end else begin
         integral_in = sum_raw[SumW-1:0];
      end
   end

   // Derivative against the previous out-of-dead-zone sample.
   logic signed [DiffW-1:0] diff1;
   assign diff1 = e1_ext - {last_error_ff[ErrW-1], last_error_ff};

   // A sample changes the state only when it leaves stage 1 outside the dead zone.
   logic state_upd;
   assign state_upd = en2 && v1_ff && !dz1;

   always_ff @(posedge clock) begin
      if (reset) begin
         integral_ff   <= '0;
         last_error_ff <= '0;
      end else if (state_upd) begin
         integral_ff   <= integral_in;
         last_error_ff <= e1_ff;
      end
   end

   // Products of the gains (zero-extended to signed) with the stage 2 terms.
   logic signed [PropW-1:0] prop_prod;
   logic signed [IntW-1:0]  int_prod;
   logic signed [DerW-1:0]  der_prod;
   assign prop_prod = $signed({1'b0, kp_ff}) * e2_ff;
   assign int_prod  = $signed({1'b0, ki_ff}) * sum2_ff;
   assign der_prod  = $signed({1'b0, kd_ff}) * diff2_ff;

   // Sum of products, divided by 2^20 toward zero and saturated to int16; zero in the dead zone.
   localparam logic signed [AccW-1:0]  RoundBias = AccW'((1 << ProdShift) - 1);
   localparam logic signed [QuotW-1:0] QuotMax   = QuotW'(32767);
   localparam logic signed [QuotW-1:0] QuotMin   = -QuotW'(32768);

   logic signed [AccW-1:0]  acc, acc_biased;
   logic signed [QuotW-1:0] quot;
   assign acc        = AccW'(prop3_ff) + AccW'(int3_ff) + AccW'(der3_ff);
   assign acc_biased = acc + (acc[AccW-1] ? RoundBias : AccW'(0));
   assign quot       = $signed(acc_biased[AccW-1:ProdShift]);

   always_comb begin
      if (dz3_ff) begin
         drive4_in = '0;
      end else if (quot > QuotMax) begin
         drive4_in = QuotMax[OutW-1:0];
      end else if (quot < QuotMin) begin
         drive4_in = QuotMin[OutW-1:0];
      end else begin
         drive4_in = quot[OutW-1:0];
      end
   end

   // Pipeline valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_ch.valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // Pipeline payload.
   always_ff @(posedge clock) begin
      if (en1) begin
         e1_ff <= req_ch.error_sample;
      end
      if (en2) begin
         e2_ff    <= e1_ff;
         sum2_ff  <= integral_in;
         diff2_ff <= diff1;
         dz2_ff   <= dz1;
      end
      if (en3) begin
         prop3_ff <= prop_prod;
         int3_ff  <= int_prod;
         der3_ff  <= der_prod;
         dz3_ff   <= dz2_ff;
      end
      if (en4) begin
         drive4_ff <= drive4_in;
         dz4_ff    <= dz3_ff;
      end
   end

   assign rsp_ch.valid        = v4_ff;
   assign rsp_ch.drive_value  = drive4_ff;
   assign rsp_ch.in_dead_zone = dz4_ff;

   // With all four stages full and the receiver stalled, no request may enter.
   assert property (@(posedge clock) disable iff (reset)
      (v1_ff && v2_ff && v3_ff && v4_ff && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("request accepted into a full, stalled pipeline");

   // The controller state moves only for a sample that leaves stage 1 outside the dead zone.
   assert property (@(posedge clock) disable iff (reset)
      !state_upd |=> ($stable(integral_ff) && $stable(last_error_ff)))
      else $error("controller state changed without an updating sample");

   // After an update the last error holds the sample that caused it.
   assert property (@(posedge clock) disable iff (reset)
      state_upd |=> (last_error_ff == $past(e1_ff)))
      else $error("last error does not match the updating sample");

endmodule

`default_nettype wire
